@@ hw/rtl/dmcc_pkg.sv @@
package dmcc_pkg;

	localparam int MAX_LINES_DEF  = 4096;
	localparam int MAX_PIXELS_DEF = 65536;

	// speed of light in m/s
	localparam logic [29:0] LIGHT_SPEED = 30'd299792458;

	// width used to clamp the line count against the depth
	localparam int CNT_W = 17;

	localparam int DIVIDEND_W = 64;
	localparam int DIVISOR_W  = 34;

	typedef enum logic [1:0] {
		REG_RADIAL_VELOCITY      = 2'd0,
		REG_BARYCENTRIC_VELOCITY = 2'd1,
		REG_MASK_LINES           = 2'd2
	} reg_index_t;

	typedef enum logic {
		OP_LOAD_LINE = 1'b0,
		OP_SAMPLE    = 1'b1
	} op_t;

	typedef struct packed {
		logic                  start;
		logic [DIVIDEND_W-1:0] dividend;
		logic [DIVISOR_W-1:0]  divisor;
	} div_req_t;

	typedef struct packed {
		logic                  done;
		logic [DIVIDEND_W-1:0] quotient;
	} div_rsp_t;

endpackage

@@ hw/rtl/dmcc_if.sv @@
interface dmcc_in_if;
	logic        valid;
	logic        ready;
	logic        operation;
	logic [11:0] mask_index;
	logic [31:0] edge_low;
	logic [31:0] edge_high;
	logic [15:0] line_weight;
	logic [31:0] wavelength;
	logic signed [31:0] flux;
	logic [15:0] snr_scale;
	logic        last_sample;

	modport source (output valid, operation, mask_index, edge_low, edge_high, line_weight,
		wavelength, flux, snr_scale, last_sample, input ready);
	modport sink (input valid, operation, mask_index, edge_low, edge_high, line_weight,
		wavelength, flux, snr_scale, last_sample, output ready);
endinterface

interface dmcc_out_if;
	logic        valid;
	logic        ready;
	logic [15:0] pixel_index;
	logic signed [47:0] pixel_value;
	logic signed [63:0] running_sum;
	logic [47:0] weight_sum;
	logic        last;

	modport source (output valid, pixel_index, pixel_value, running_sum, weight_sum, last,
		input ready);
	modport sink (input valid, pixel_index, pixel_value, running_sum, weight_sum, last,
		output ready);
endinterface

@@ hw/rtl/dmcc_divider.sv @@
// restoring divider, one quotient bit per cycle
module dmcc_divider (
	input  logic                clk,
	input  logic                arst_n,
	input  dmcc_pkg::div_req_t  req,
	output dmcc_pkg::div_rsp_t  rsp
);
	localparam int NW = dmcc_pkg::DIVIDEND_W;
	localparam int DW = dmcc_pkg::DIVISOR_W;
	localparam int CW = $clog2(NW + 1);

	logic [DW-1:0] rem_q;
	logic [NW-1:0] quo_q;
	logic [DW-1:0] div_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic          done_q;

	logic [DW:0] trial;
	logic        take;

	assign trial = {rem_q, quo_q[NW-1]};
	assign take  = trial >= {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q  <= '0;
			quo_q  <= '0;
			div_q  <= '0;
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				rem_q  <= '0;
				quo_q  <= req.dividend;
				div_q  <= req.divisor;
				cnt_q  <= CW'(NW);
				busy_q <= 1'b1;
			end else if (busy_q) begin
				// remainder stays below the divisor, so its top bit is always clear
				rem_q <= take ? DW'(trial - {1'b0, div_q}) : trial[DW-1:0];
				quo_q <= {quo_q[NW-2:0], take};
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign rsp.done     = done_q;
	assign rsp.quotient = quo_q;

endmodule

@@ hw/rtl/doppler_mask_cross_correlation_core.sv @@
// channel | dir | handshake   | payload
// din     | in  | valid/ready | operation, mask_index, edges, weight, sample fields, last_sample
// dout    | out | valid/ready | pixel_index, pixel_value, running_sum, weight_sum, last
// cfg     | in  | cfg_we      | cfg_index, cfg_data (velocities, line count)
//
// a load word makes two 64-step passes through the shared divider, each after a
// multiply step, then the memory write
// a sample word walks the pointer past lines ending below the pixel, up to the last line,
// classifies the overlap (the divider gives the fraction of a partial one), multiplies
// on a hit, then accumulates and outputs; the first two samples of a pass give no result
// din is not ready while a word is in work; a result waits in the output register
// arst_n clears control and sums; the mask memories hold garbage until loaded
module doppler_mask_cross_correlation_core #(
	parameter int MAX_LINES  = dmcc_pkg::MAX_LINES_DEF,
	parameter int MAX_PIXELS = dmcc_pkg::MAX_PIXELS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	dmcc_in_if.sink     din,
	dmcc_out_if.source  dout,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [20:0] cfg_data
);
	localparam int AW = $clog2(MAX_LINES);
	localparam int SW = $clog2(MAX_PIXELS + 2);
	localparam int NW = dmcc_pkg::CNT_W;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_LD_LO_MUL,
		ST_LD_LO_DIV,
		ST_LD_HI_MUL,
		ST_LD_HI_DIV,
		ST_LD_WR,
		ST_WALK_WAIT,
		ST_WALK_CHK,
		ST_FRAC,
		ST_FRAC_DIV,
		ST_MUL1,
		ST_MUL2,
		ST_MUL3,
		ST_ACC,
		ST_OUT,
		ST_FINISH
	} state_t;

	state_t state_q;

	// config registers
	logic signed [20:0] rv_q, bv_q;
	logic [12:0]        ml_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rv_q <= '0;
			bv_q <= '0;
			ml_q <= 13'd1;
		end else if (cfg_we) begin
			case (cfg_index)
				dmcc_pkg::REG_RADIAL_VELOCITY:      rv_q <= cfg_data;
				dmcc_pkg::REG_BARYCENTRIC_VELOCITY: bv_q <= cfg_data;
				dmcc_pkg::REG_MASK_LINES:           ml_q <= cfg_data[12:0];
				default: ;
			endcase
		end
	end

	// doppler factor terms, always positive
	logic signed [30:0] num_s, den_s;
	logic [28:0]        dop_num, dop_den;
	assign num_s   = $signed({1'b0, dmcc_pkg::LIGHT_SPEED}) + 31'(rv_q);
	assign den_s   = $signed({1'b0, dmcc_pkg::LIGHT_SPEED}) + 31'(bv_q);
	assign dop_num = num_s[28:0];
	assign dop_den = den_s[28:0];

	// effective line count minus one
	logic [NW-1:0] ml_ext, n_lines, n_m1;
	assign ml_ext  = NW'(ml_q);
	assign n_lines = (ml_ext == '0) ? NW'(1) :
		((ml_ext > NW'(MAX_LINES)) ? NW'(MAX_LINES) : ml_ext);
	assign n_m1    = n_lines - NW'(1);

	// mask memories
	logic [31:0] lo_mem [MAX_LINES];
	logic [31:0] hi_mem [MAX_LINES];
	logic [15:0] w_mem  [MAX_LINES];
	logic [31:0] lo_rd_q, hi_rd_q;
	logic [15:0] w_rd_q;
	logic [AW-1:0] ptr_q;
	logic          at_end_q;

	// load word latches
	logic [AW-1:0] slot_q;
	logic          slot_ok_q;
	logic [31:0]   ld_lo_q, ld_hi_q, sh_lo_q;
	logic [15:0]   ld_w_q;
	logic [31:0]   sat_edge;

	always_ff @(posedge clk) begin
		if (state_q == ST_LD_WR && slot_ok_q) begin
			lo_mem[slot_q] <= sh_lo_q;
			hi_mem[slot_q] <= sat_edge;
			w_mem[slot_q]  <= ld_w_q;
		end
		lo_rd_q <= lo_mem[ptr_q];
		hi_rd_q <= hi_mem[ptr_q];
		w_rd_q  <= w_mem[ptr_q];
	end

	// shared divider
	dmcc_pkg::div_req_t div_req;
	dmcc_pkg::div_rsp_t div_rsp;

	dmcc_divider u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// edge times doppler numerator plus half the denominator, captured by the divider
	logic [31:0] ld_edge;
	logic [63:0] ld_prod;
	assign ld_edge  = (state_q == ST_LD_HI_MUL) ? ld_hi_q : ld_lo_q;
	assign ld_prod  = 64'(ld_edge) * 64'(dop_num) + 64'(dop_den >> 1);
	assign sat_edge = (div_rsp.quotient[63:32] != '0) ? 32'hFFFF_FFFF : div_rsp.quotient[31:0];

	// spectrum history and pixel work
	logic [31:0]        older_q, middle_q, cur_wav_q;
	logic signed [31:0] mflux_q, cur_flux_q;
	logic [15:0]        msnr_q, cur_snr_q;
	logic               cur_last_q;
	logic [SW-1:0]      seen_q;
	logic signed [63:0] csum_q;
	logic [47:0]        wtot_q;
	logic [32:0]        init2_q, end2_q;
	logic [16:0]        frac_q;
	logic               hit_q;
	logic [15:0]        wf_q;
	logic [24:0]        ws_q;
	logic signed [57:0] prod_q;

	// overlap classification
	logic [32:0] lo2, hi2, span2;
	logic        c_full, c_right, c_left, c_mid;
	logic [33:0] frac_num;
	assign lo2     = {lo_rd_q, 1'b0};
	assign hi2     = {hi_rd_q, 1'b0};
	assign span2   = end2_q - init2_q;
	assign c_full  = (end2_q < hi2) && (init2_q > lo2);
	assign c_right = (end2_q < hi2) && (init2_q < lo2) && (end2_q > lo2);
	assign c_left  = (end2_q > hi2) && (init2_q > lo2) && (init2_q < hi2);
	assign c_mid   = (end2_q > hi2) && (init2_q < lo2);
	always_comb begin
		if (c_right)     frac_num = 34'(end2_q - lo2);
		else if (c_left) frac_num = 34'(hi2 - init2_q);
		else             frac_num = 34'(hi2 - lo2);
	end

	// walk step
	logic walk_more;
	assign walk_more = !at_end_q && (hi2 < init2_q);

	// divider request
	always_comb begin
		div_req.start    = 1'b0;
		div_req.dividend = ld_prod;
		div_req.divisor  = 34'(dop_den);
		case (state_q)
			ST_LD_LO_MUL, ST_LD_HI_MUL: div_req.start = 1'b1;
			ST_FRAC: begin
				div_req.start    = c_right || c_left || (c_mid && hi2 >= lo2);
				div_req.dividend = {14'd0, frac_num, 16'd0} + 64'(span2 >> 1);
				div_req.divisor  = 34'(span2);
			end
			default: ;
		endcase
	end

	// accumulate terms
	logic signed [41:0] value;
	logic signed [64:0] csum_add;
	logic signed [63:0] csum_next;
	logic [48:0]        wtot_add;
	assign value    = 42'(prod_q >>> 16);
	assign csum_add = 65'(csum_q) + 65'(value);
	always_comb begin
		if (csum_add[64] != csum_add[63])
			csum_next = csum_add[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
		else
			csum_next = csum_add[63:0];
	end
	assign wtot_add = 49'(wtot_q) + 49'(ws_q);

	logic [31:0] idx_w;
	assign idx_w = 32'(seen_q) - 32'd2;

	logic [15:0]        o_idx_q;
	logic signed [47:0] o_val_q;
	logic signed [63:0] o_sum_q;
	logic [47:0]        o_wsum_q;
	logic               o_last_q, o_valid_q;
	logic signed [41:0] val_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			ptr_q      <= '0;
			at_end_q   <= 1'b0;
			slot_q     <= '0;
			slot_ok_q  <= 1'b0;
			ld_lo_q    <= '0;
			ld_hi_q    <= '0;
			ld_w_q     <= '0;
			sh_lo_q    <= '0;
			older_q    <= '0;
			middle_q   <= '0;
			mflux_q    <= '0;
			msnr_q     <= '0;
			cur_wav_q  <= '0;
			cur_flux_q <= '0;
			cur_snr_q  <= '0;
			cur_last_q <= 1'b0;
			seen_q     <= '0;
			csum_q     <= '0;
			wtot_q     <= '0;
			init2_q    <= '0;
			end2_q     <= '0;
			frac_q     <= '0;
			hit_q      <= 1'b0;
			wf_q       <= '0;
			ws_q       <= '0;
			prod_q     <= '0;
			val_q      <= '0;
			o_idx_q    <= '0;
			o_val_q    <= '0;
			o_sum_q    <= '0;
			o_wsum_q   <= '0;
			o_last_q   <= 1'b0;
			o_valid_q  <= 1'b0;
		end else begin
			// the output step reloads the register itself
			if (o_valid_q && dout.ready && state_q != ST_OUT) o_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (din.valid) begin
						if (din.operation == dmcc_pkg::OP_LOAD_LINE) begin
							slot_q    <= AW'(din.mask_index);
							slot_ok_q <= NW'(din.mask_index) < NW'(MAX_LINES);
							ld_lo_q   <= din.edge_low;
							ld_hi_q   <= din.edge_high;
							ld_w_q    <= din.line_weight;
							state_q   <= ST_LD_LO_MUL;
						end else begin
							cur_wav_q  <= din.wavelength;
							cur_flux_q <= din.flux;
							cur_snr_q  <= din.snr_scale;
							cur_last_q <= din.last_sample;
							init2_q    <= 33'(older_q) + 33'(middle_q);
							end2_q     <= 33'(middle_q) + 33'(din.wavelength);
							state_q    <= (seen_q >= SW'(2)) ? ST_WALK_WAIT : ST_FINISH;
						end
					end
				end
				ST_LD_LO_MUL: state_q <= ST_LD_LO_DIV;
				ST_LD_LO_DIV: begin
					if (div_rsp.done) begin
						sh_lo_q <= sat_edge;
						state_q <= ST_LD_HI_MUL;
					end
				end
				ST_LD_HI_MUL: state_q <= ST_LD_HI_DIV;
				ST_LD_HI_DIV: begin
					// quotient stays put after done, the write uses it next cycle
					if (div_rsp.done) state_q <= ST_LD_WR;
				end
				ST_LD_WR: state_q <= ST_IDLE;
				ST_WALK_WAIT: state_q <= ST_WALK_CHK;
				ST_WALK_CHK: begin
					if (walk_more) begin
						if (NW'(ptr_q) >= n_m1) begin
							at_end_q <= 1'b1;
						end else begin
							ptr_q   <= ptr_q + 1'b1;
							state_q <= ST_WALK_WAIT;
						end
					end else begin
						state_q <= ST_FRAC;
					end
				end
				ST_FRAC: begin
					hit_q <= c_full || c_right || c_left || c_mid;
					if (c_full) begin
						frac_q  <= 17'd65536;
						state_q <= ST_MUL1;
					end else if (div_req.start) begin
						state_q <= ST_FRAC_DIV;
					end else if (c_mid) begin
						// inverted line
						frac_q  <= '0;
						state_q <= ST_MUL1;
					end else begin
						state_q <= ST_ACC;
					end
				end
				ST_FRAC_DIV: begin
					if (div_rsp.done) begin
						frac_q  <= div_rsp.quotient[16:0];
						state_q <= ST_MUL1;
					end
				end
				ST_MUL1: begin
					wf_q    <= 16'((33'(w_rd_q) * 33'(frac_q) + 33'd32768) >> 16);
					state_q <= ST_MUL2;
				end
				ST_MUL2: begin
					ws_q    <= 25'((33'(wf_q) * 33'(msnr_q) + 33'd128) >> 8);
					state_q <= ST_MUL3;
				end
				ST_MUL3: begin
					prod_q  <= 58'(mflux_q) * $signed(58'(ws_q)) + 58'sd32768;
					state_q <= ST_ACC;
				end
				ST_ACC: begin
					if (hit_q) begin
						val_q  <= value;
						csum_q <= csum_next;
						wtot_q <= wtot_add[48] ? {48{1'b1}} : wtot_add[47:0];
					end else begin
						val_q <= '0;
					end
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (!o_valid_q || dout.ready) begin
						o_valid_q <= 1'b1;
						o_idx_q   <= idx_w[15:0];
						o_val_q   <= 48'(val_q);
						o_sum_q   <= csum_q;
						o_wsum_q  <= wtot_q;
						o_last_q  <= cur_last_q;
						state_q   <= ST_FINISH;
					end
				end
				ST_FINISH: begin
					if (cur_last_q) begin
						ptr_q    <= '0;
						at_end_q <= 1'b0;
						older_q  <= '0;
						middle_q <= '0;
						mflux_q  <= '0;
						msnr_q   <= '0;
						seen_q   <= '0;
						csum_q   <= '0;
						wtot_q   <= '0;
					end else begin
						older_q  <= middle_q;
						middle_q <= cur_wav_q;
						mflux_q  <= cur_flux_q;
						msnr_q   <= cur_snr_q;
						if (seen_q < SW'(MAX_PIXELS + 1)) seen_q <= seen_q + 1'b1;
					end
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign din.ready        = (state_q == ST_IDLE);
	assign dout.valid       = o_valid_q;
	assign dout.pixel_index = o_idx_q;
	assign dout.pixel_value = o_val_q;
	assign dout.running_sum = o_sum_q;
	assign dout.weight_sum  = o_wsum_q;
	assign dout.last        = o_last_q;

	// divider only finishes while the sequencer waits for it
	a_div_done_waited: assert property (@(posedge clk) disable iff (!arst_n)
		div_rsp.done |-> (state_q == ST_LD_LO_DIV || state_q == ST_LD_HI_DIV ||
			state_q == ST_FRAC_DIV))
		else $error("divider finished outside a wait state");

	// pointer never passes the last line in use
	a_ptr_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WALK_CHK) |-> (NW'(ptr_q) <= n_m1))
		else $error("line pointer beyond line count");

	// sample count saturates
	a_seen_bound: assert property (@(posedge clk) disable iff (!arst_n)
		seen_q <= SW'(MAX_PIXELS + 1))
		else $error("sample count overflow");

	// a new result is only loaded from the output step
	a_out_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(o_valid_q) |-> $past(state_q) == ST_OUT)
		else $error("result raised outside output step");

endmodule

@@ verif/dmcc_checker.sv @@
module dmcc_checker (
	input  logic clk,
	input  logic arst_n,
	dmcc_in_if   din,
	dmcc_out_if  dout,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [20:0] cfg_data,
	output int          errors,
	output int          pending
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int NLINES = dmcc_pkg::MAX_LINES_DEF;
	localparam longint unsigned MAX48 = 64'hFFFF_FFFF_FFFF;

	typedef struct packed {
		logic [15:0] idx;
		logic [47:0] val;
		logic [63:0] sum;
		logic [47:0] wsum;
		logic        lst;
	} pixel_t;

	pixel_t pixel_q[$];

	logic [31:0] lo_mem [NLINES];
	logic [31:0] hi_mem [NLINES];
	logic [15:0] w_mem  [NLINES];

	logic signed [20:0] rv_reg, bv_reg;
	logic [12:0] nlines_reg;
	int unsigned ptr;
	logic at_end;
	logic [31:0] older_wl, mid_wl, mid_flux;
	logic [15:0] mid_snr;
	int unsigned seen;
	longint sum_acc;
	longint unsigned wsum_acc;

	assign pending = pixel_q.size();

	function automatic logic [31:0] dop_shift(logic [31:0] e);
		longint unsigned nm, dn, q;
		nm = longint'(dmcc_pkg::LIGHT_SPEED) + longint'(rv_reg);
		dn = longint'(dmcc_pkg::LIGHT_SPEED) + longint'(bv_reg);
		q = (longint'(e) * nm + dn / 2) / dn;
		return q > 64'hFFFF_FFFF ? 32'hFFFF_FFFF : q[31:0];
	endfunction

	function automatic longint unsigned frac_q16(longint unsigned num, longint unsigned den);
		return ((num << 16) + den / 2) / den;
	endfunction

	task automatic clear_pass();
		ptr = 0;
		at_end = 1'b0;
		older_wl = '0;
		mid_wl = '0;
		mid_flux = '0;
		mid_snr = '0;
		seen = 0;
		sum_acc = 0;
		wsum_acc = 0;
	endtask

	// per-sample prediction: pointer walk, overlap case, weighted flux, sums
	task automatic predict_sample();
		int unsigned n, p;
		longint unsigned init2, end2, lo2, hi2, frac, wf, ws;
		longint val, prod;
		logic hit;
		pixel_t px;
		if (seen >= 2) begin
			n = nlines_reg == 0 ? 1 : (nlines_reg > NLINES ? NLINES : nlines_reg);
			init2 = longint'(older_wl) + longint'(mid_wl);
			end2 = longint'(mid_wl) + longint'(din.wavelength);
			p = ptr;
			while (!at_end && 2 * longint'(hi_mem[p]) < init2) begin
				if (p >= n - 1) at_end = 1'b1;
				else p++;
			end
			ptr = p;
			lo2 = 2 * longint'(lo_mem[p]);
			hi2 = 2 * longint'(hi_mem[p]);
			frac = 0;
			hit = 1'b1;
			if (end2 < hi2 && init2 > lo2) frac = 65536;
			else if (end2 < hi2 && init2 < lo2 && end2 > lo2)
				frac = frac_q16(end2 - lo2, end2 - init2);
			else if (end2 > hi2 && init2 > lo2 && init2 < hi2)
				frac = frac_q16(hi2 - init2, end2 - init2);
			else if (end2 > hi2 && init2 < lo2)
				frac = hi2 >= lo2 ? frac_q16(hi2 - lo2, end2 - init2) : 0;
			else hit = 1'b0;
			val = 0;
			if (hit) begin
				wf = (longint'(w_mem[p]) * frac + 32768) >> 16;
				ws = (wf * longint'(mid_snr) + 128) >> 8;
				prod = longint'($signed(mid_flux)) * longint'(ws) + 32768;
				val = prod >>> 16;
				if (val > 0 && sum_acc > 64'sh7FFF_FFFF_FFFF_FFFF - val)
					sum_acc = 64'sh7FFF_FFFF_FFFF_FFFF;
				else if (val < 0 && sum_acc < -64'sh7FFF_FFFF_FFFF_FFFF - 1 - val)
					sum_acc = -64'sh7FFF_FFFF_FFFF_FFFF - 1;
				else sum_acc += val;
				wsum_acc = (wsum_acc + ws > MAX48) ? MAX48 : wsum_acc + ws;
			end
			px.idx = 16'(seen - 2);
			px.val = val[47:0];
			px.sum = sum_acc;
			px.wsum = wsum_acc[47:0];
			px.lst = din.last_sample;
			pixel_q.push_back(px);
		end
		older_wl = mid_wl;
		mid_wl = din.wavelength;
		mid_flux = din.flux;
		mid_snr = din.snr_scale;
		if (seen < dmcc_pkg::MAX_PIXELS_DEF + 1) seen++;
		if (din.last_sample) clear_pass();
	endtask

	always @(posedge clk or negedge arst_n) begin
		pixel_t exp_px, got;
		if (!arst_n) begin
			rv_reg = '0;
			bv_reg = '0;
			nlines_reg = 13'd1;
			clear_pass();
			pixel_q.delete();
			errors = 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					dmcc_pkg::REG_RADIAL_VELOCITY:      rv_reg = cfg_data;
					dmcc_pkg::REG_BARYCENTRIC_VELOCITY: bv_reg = cfg_data;
					dmcc_pkg::REG_MASK_LINES:           nlines_reg = {1'b0, cfg_data[11:0]} |
						(cfg_data[12] ? 13'h1000 : 13'h0);
					default: ;
				endcase
			end
			if (dout.valid && dout.ready) begin
				got = {dout.pixel_index, dout.pixel_value, dout.running_sum,
					dout.weight_sum, dout.last};
				if (pixel_q.size() == 0) begin
					errors++;
					if (errors <= 10) $display("unexpected result word: %p", got);
				end else begin
					exp_px = pixel_q.pop_front();
					if (got !== exp_px) begin
						errors++;
						if (errors <= 10)
							$display("mismatch: expected %p actual %p", exp_px, got);
					end
				end
			end
			if (din.valid && din.ready) begin
				if (din.operation == dmcc_pkg::OP_LOAD_LINE) begin
					lo_mem[din.mask_index] = dop_shift(din.edge_low);
					hi_mem[din.mask_index] = dop_shift(din.edge_high);
					w_mem[din.mask_index] = din.line_weight;
				end else begin
					predict_sample();
				end
			end
		end
	end
endmodule

@@ verif/doppler_mask_cross_correlation_core_tb.sv @@
module doppler_mask_cross_correlation_core_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int QUIET_LIMIT = 40000;
	localparam int SETTLE = 400;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [1:0]  cfg_index = dmcc_pkg::REG_RADIAL_VELOCITY;
	logic [20:0] cfg_data = '0;
	int errors, pending;
	int words_in = 0;
	int cyc = 0;
	int quiet = 0;
	bit idle_ok = 1'b1;

	dmcc_in_if  din_if();
	dmcc_out_if dout_if();

	doppler_mask_cross_correlation_core dut (
		.clk(clk), .arst_n(arst_n), .din(din_if), .dout(dout_if),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	dmcc_checker chk (
		.clk(clk), .arst_n(arst_n), .din(din_if), .dout(dout_if),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.errors(errors), .pending(pending)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// all inputs known from time zero
	initial begin
		din_if.valid = 1'b0;
		din_if.operation = dmcc_pkg::OP_SAMPLE;
		din_if.mask_index = '0;
		din_if.edge_low = '0;
		din_if.edge_high = '0;
		din_if.line_weight = '0;
		din_if.wavelength = '0;
		din_if.flux = '0;
		din_if.snr_scale = '0;
		din_if.last_sample = 1'b0;
		dout_if.ready = 1'b0;
	end

	// receiver: random stalls, a clean stretch, and one long hold-off to back up the core
	// the hold-off starts on the first pixel of a pass that has not ended, so more samples are still coming
	initial begin
		int hold;
		bit held;
		hold = 0;
		held = 1'b0;
		forever begin
			@(posedge clk);
			cyc++;
			if (!held && cyc >= 6000 && dout_if.valid && !dout_if.last &&
				dout_if.pixel_index == 16'd0) begin
				hold = 3000;
				held = 1'b1;
			end
			if (hold > 0) begin
				dout_if.ready <= 1'b0;
				hold--;
			end else if (cyc > 20000 && cyc < 60000) begin
				dout_if.ready <= 1'b1;
			end else begin
				dout_if.ready <= ($urandom_range(0, 99) >= 8);
			end
		end
	end

	// watchdog on cycles with no word moving on either channel
	always @(posedge clk) begin
		if (arst_n) begin
			if ((din_if.valid && din_if.ready) || (dout_if.valid && dout_if.ready)) quiet = 0;
			else quiet++;
			if (quiet >= QUIET_LIMIT) begin
				$display("[doppler_mask_cross_correlation_core] ERROR");
				$finish;
			end
		end
	end

	// offer one word and hold it until the core takes it
	task automatic put_word(dmcc_pkg::op_t op, logic [11:0] idx, logic [31:0] lo,
		logic [31:0] hi, logic [15:0] w, logic [31:0] wl, logic [31:0] fx,
		logic [15:0] snr, logic lst);
		while (idle_ok && $urandom_range(0, 99) < 8) begin
			din_if.valid <= 1'b0;
			@(posedge clk);
		end
		din_if.valid <= 1'b1;
		din_if.operation <= op;
		din_if.mask_index <= idx;
		din_if.edge_low <= lo;
		din_if.edge_high <= hi;
		din_if.line_weight <= w;
		din_if.wavelength <= wl;
		din_if.flux <= fx;
		din_if.snr_scale <= snr;
		din_if.last_sample <= lst;
		@(posedge clk);
		while (!din_if.ready) @(posedge clk);
		words_in++;
		// clean stretch with no sender gaps
		idle_ok = !(words_in > 400 && words_in < 600);
	endtask

	task automatic load_line(logic [11:0] idx, logic [31:0] lo, logic [31:0] hi, logic [15:0] w);
		put_word(dmcc_pkg::OP_LOAD_LINE, idx, lo, hi, w, $urandom, $urandom, 16'($urandom),
			1'($urandom));
	endtask

	task automatic sample(logic [31:0] wl, logic [31:0] fx, logic [15:0] snr, logic lst);
		put_word(dmcc_pkg::OP_SAMPLE, 12'($urandom), $urandom, $urandom, 16'($urandom), wl, fx,
			snr, lst);
	endtask

	// wait out all results plus the load latency before touching a register
	task automatic write_reg(dmcc_pkg::reg_index_t idx, logic [20:0] data);
		din_if.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	function automatic logic [20:0] pick_velocity();
		case ($urandom_range(0, 4))
			0: return 21'(-1000000);
			1: return 21'(1000000);
			2: return '0;
			default: return 21'($urandom_range(0, 2000000) - 1000000);
		endcase
	endfunction

	// one pass: configure, load lines 0..k-1, stream samples across them
	task automatic run_pass();
		int k, nsamp, n;
		bit stopper;
		logic [31:0] base, pos, lo, hi, tmp, wl;
		k = $urandom_range(1, 8);
		stopper = ($urandom_range(0, 3) == 0);
		if (stopper) n = ($urandom_range(0, 2) == 0) ? 4096 : $urandom_range(k + 1, 4096);
		else n = $urandom_range(0, k);
		write_reg(dmcc_pkg::REG_RADIAL_VELOCITY, pick_velocity());
		write_reg(dmcc_pkg::REG_BARYCENTRIC_VELOCITY, pick_velocity());
		write_reg(dmcc_pkg::REG_MASK_LINES, 21'(n));
		base = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 32'hF000_0000)
			: $urandom_range(0, 1 << 20);
		pos = base;
		for (int i = 0; i < k; i++) begin
			lo = pos + $urandom_range(0, 3000);
			hi = lo + $urandom_range(0, 4000);
			if ($urandom_range(0, 9) == 0) begin
				tmp = lo;
				lo = hi + 1;
				hi = tmp;
			end
			// last line reaches the top so the walk never leaves the loaded slots
			if (stopper && i == k - 1) hi = 32'hFFFF_FFFF;
			load_line(12'(i), lo, hi, 16'($urandom));
			pos = hi + $urandom_range(0, 2000);
		end
		nsamp = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 3) : $urandom_range(8, 40);
		wl = base - $urandom_range(0, 3000);
		if (wl > base) wl = 0;
		for (int i = 0; i < nsamp; i++) begin
			// a stray load to a slot beyond the walk, now and then
			if ($urandom_range(0, 29) == 0)
				load_line(12'($urandom_range(k, 4095)), $urandom, $urandom, 16'($urandom));
			if ($urandom_range(0, 24) == 0 && !stopper) wl = $urandom;
			else wl = wl + $urandom_range(1, 1500);
			if (stopper && wl > 32'hF100_0000) wl = 32'hF100_0000;
			sample(wl, $urandom, 16'($urandom), i == nsamp - 1);
		end
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: reset settings, field extremes, equal-edge no overlap, short pass
		load_line(12'd0, 32'd1000, 32'd5000, 16'hFFFF);
		load_line(12'd4095, 32'hFFFF_FFFF, 32'h0, 16'h0);
		sample(32'd0, 32'h7FFF_FFFF, 16'hFFFF, 1'b0);
		sample(32'd2000, 32'h8000_0000, 16'hFFFF, 1'b0);
		sample(32'd3000, 32'h0001_0000, 16'h0100, 1'b0);
		load_line(12'd1, 32'd9000, 32'd9500, 16'h8000);
		sample(32'd5000, 32'hFFFF_FFFF, 16'h0000, 1'b0);
		sample(32'd9000, 32'h8000_0000, 16'hFFFF, 1'b0);
		sample(32'hFFFF_FFFF, 32'h7FFF_FFFF, 16'hFFFF, 1'b1);
		// inverted line straddled by a wide pixel
		load_line(12'd0, 32'd3000, 32'd2000, 16'hFFFF);
		sample(32'd0, 32'h0001_0000, 16'h0100, 1'b0);
		sample(32'd1000, 32'h0002_0000, 16'h0100, 1'b0);
		sample(32'd10000, 32'h0003_0000, 16'h0100, 1'b0);
		sample(32'd20000, 32'h0004_0000, 16'h0100, 1'b1);
		// pass of two samples gives nothing
		sample(32'd100, 32'h1234_5678, 16'h1111, 1'b0);
		sample(32'd200, 32'h8765_4321, 16'h2222, 1'b1);
		// extreme velocities and line count
		write_reg(dmcc_pkg::REG_RADIAL_VELOCITY, 21'(1000000));
		write_reg(dmcc_pkg::REG_BARYCENTRIC_VELOCITY, 21'(-1000000));
		write_reg(dmcc_pkg::REG_MASK_LINES, 21'd4096);
		load_line(12'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'h1);
		write_reg(dmcc_pkg::REG_MASK_LINES, 21'd0);
		sample(32'h8000_0000, 32'h7FFF_FFFF, 16'hFFFF, 1'b0);
		sample(32'hC000_0000, 32'h8000_0000, 16'hFFFF, 1'b0);
		sample(32'hFFFF_FFF0, 32'h0000_0001, 16'h8000, 1'b1);

		while (words_in < 1150) run_pass();

		din_if.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
		if (errors == 0 && pending == 0) begin
			$display("[doppler_mask_cross_correlation_core] OK");
		end else begin
			$display("[doppler_mask_cross_correlation_core] ERROR");
		end
		$finish;
	end
endmodule
